// File: hw/rtl/hrhp_pkg.sv
// ============================================================================
// hrhp_pkg - shared types and constants of the HTTP response head parser
// Parse states, status codes, the per-byte state record and the result record.
// ============================================================================
package hrhp_pkg;

  // Width of the running byte offset; it saturates at all ones.
  localparam int OFFSET_BITS = 16;
  localparam int FIELD_W     = 16;
  localparam int CODE_W      = 10;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 5;

  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [1:0] LAST_DIGIT = 2'd3;
  localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

  typedef enum logic [21:0] {
    PS_START     = 22'h000001,
    PS_H         = 22'h000002,
    PS_HT        = 22'h000004,
    PS_HTT       = 22'h000008,
    PS_HTTP      = 22'h000010,
    PS_MAJ_FIRST = 22'h000020,
    PS_MAJ       = 22'h000040,
    PS_MIN_FIRST = 22'h000080,
    PS_MIN       = 22'h000100,
    PS_DIGITS    = 22'h000200,
    PS_AFTER_CODE = 22'h000400,
    PS_REASON    = 22'h000800,
    PS_LINE_LF   = 22'h001000,
    PS_KEY_FIRST = 22'h002000,
    PS_KEY       = 22'h004000,
    PS_VAL_FIRST = 22'h008000,
    PS_VAL       = 22'h010000,
    PS_VAL_LF    = 22'h020000,
    PS_NEXT_LINE = 22'h040000,
    PS_END_LF    = 22'h080000,
    PS_BODY      = 22'h100000,
    PS_FAIL      = 22'h200000
  } parse_state_t;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_ERR  = 2'd1,
    ST_DONE = 2'd2,
    ST_BODY = 2'd3
  } parse_status_t;

  typedef struct packed {
    parse_state_t           parse_state;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [CODE_W-1:0]      code_accumulator;
    logic [1:0]             digit_count;
    logic [FIELD_W-1:0]     field_start;
    logic [FIELD_W-1:0]     field_count;
  } parse_ctx_t;

  localparam parse_ctx_t CTX_RESET = '{
    parse_state:      PS_START,
    byte_offset:      '0,
    code_accumulator: '0,
    digit_count:      '0,
    field_start:      '0,
    field_count:      '0
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_response;
  } in_item_t;

  typedef struct packed {
    parse_status_t      parse_status;
    logic               code_valid;
    logic [CODE_W-1:0]  status_code;
    logic [FIELD_W-1:0] code_offset;
    logic               key_done;
    logic [FIELD_W-1:0] key_offset;
    logic [FIELD_W-1:0] key_length;
    logic               value_done;
    logic [FIELD_W-1:0] value_offset;
    logic [FIELD_W-1:0] value_length;
    logic [FIELD_W-1:0] head_end_offset;
  } result_t;

  // Low result-field bits of an offset, for any offset width.
  function automatic logic [FIELD_W-1:0] to_field(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+FIELD_W-1:0] w;
    w = {{FIELD_W{1'b0}}, v};
    return w[FIELD_W-1:0];
  endfunction

endpackage

// File: hw/rtl/http_response_head_parser_core.sv
// ============================================================================
// http_response_head_parser_core - HTTP response head parser, top level
// Status line check, status code, header key/value delimiting, one byte per
// transfer.
// ============================================================================
//
//  channel  dir  tdata                         tuser
//  -------  ---  ----------------------------  -------------------------------
//  s_*      in   data_byte                     new_response
//  m_*      out  code, offsets and lengths     status, code/key/value strobes
//
//  One byte per cycle while m_* does not stall; a byte reaches m_* through the
//  input register, then the result register behind the step.
//  The loop that sets the rate is the parse context register fed back through
//  the combinational step logic.
//  rst (synchronous, active high) empties both registers and puts the parser
//  in its start state, as does new_response on the byte that carries it.
//  A stall on m_* holds the result; the input register still takes one more
//  byte, after which s_tready drops until the result is taken.
//
module http_response_head_parser_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] data_byte
  input  logic [hrhp_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [0] new_response
  input  logic [hrhp_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [9:0] status_code, [25:10] code_offset, [41:26] key_offset,
  // [57:42] key_length, [73:58] value_offset, [89:74] value_length,
  // [105:90] head_end_offset, [111:106] zero
  output logic [hrhp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // [1:0] parse_status, [2] code_valid, [3] key_done, [4] value_done
  output logic [hrhp_pkg::OUT_TUSER_W-1:0]    m_tuser
);
  import hrhp_pkg::*;

  logic       item_valid;
  in_item_t   item;
  logic       advance;
  parse_ctx_t ctx;
  parse_ctx_t ctx_next;
  result_t    res_next;
  result_t    res;

  // step fires when a byte is held and the result register is free
  assign advance = item_valid && (!m_tvalid || m_tready);

  hrhp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  hrhp_step u_step (
    .ctx      (ctx),
    .item     (item),
    .ctx_next (ctx_next),
    .res      (res_next)
  );

  // parse context: updated once per byte that goes through the step
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= CTX_RESET;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {6'b0, res.head_end_offset, res.value_length, res.value_offset,
                    res.key_length, res.key_offset, res.code_offset, res.status_code};
  assign m_tuser = {res.value_done, res.key_done, res.code_valid, res.parse_status};

endmodule

// File: hw/rtl/hrhp_in_reg.sv
// ============================================================================
// hrhp_in_reg - input register stage
// Holds one incoming byte until the parser step takes it.
// ============================================================================
module hrhp_in_reg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [hrhp_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] data_byte
  input  logic [hrhp_pkg::IN_TUSER_W-1:0]    s_tuser,   // [0] new_response
  input  logic                               take,
  output logic                               item_valid,
  output hrhp_pkg::in_item_t                 item
);
  import hrhp_pkg::*;

  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data_byte    <= s_tdata[7:0];
      item.new_response <= s_tuser[0];
    end
  end

endmodule

// File: hw/rtl/hrhp_step.sv
// ============================================================================
// hrhp_step - per-byte transition of the head parser
// Next parse context and the result record for one byte.
// ============================================================================
module hrhp_step (
  input  hrhp_pkg::parse_ctx_t ctx,
  input  hrhp_pkg::in_item_t   item,
  output hrhp_pkg::parse_ctx_t ctx_next,
  output hrhp_pkg::result_t    res
);
  import hrhp_pkg::*;

  parse_ctx_t             cur;
  logic [7:0]             c;
  logic [OFFSET_BITS-1:0] at;
  logic                   fail;
  logic                   is_dig;
  logic [CODE_W+3:0]      acc_wide;

  always_comb begin
    cur      = item.new_response ? CTX_RESET : ctx;
    c        = item.data_byte;
    at       = cur.byte_offset;
    is_dig   = c inside {[CH_0:CH_9]};
    acc_wide = {1'b0, cur.code_accumulator, 3'b000} + {3'b000, cur.code_accumulator, 1'b0}
             + {{(CODE_W){1'b0}}, c[3:0]};
    ctx_next = cur;
    res      = '0;
    fail     = 1'b0;

    case (cur.parse_state)
      PS_START: begin
        if (c == CH_H) ctx_next.parse_state = PS_H; else fail = 1'b1;
      end
      PS_H: begin
        if (c == CH_T) ctx_next.parse_state = PS_HT; else fail = 1'b1;
      end
      PS_HT: begin
        if (c == CH_T) ctx_next.parse_state = PS_HTT; else fail = 1'b1;
      end
      PS_HTT: begin
        if (c == CH_P) ctx_next.parse_state = PS_HTTP; else fail = 1'b1;
      end
      PS_HTTP: begin
        if (c == CH_SLASH) ctx_next.parse_state = PS_MAJ_FIRST; else fail = 1'b1;
      end
      PS_MAJ_FIRST: begin
        if (c inside {[CH_1:CH_9]}) ctx_next.parse_state = PS_MAJ; else fail = 1'b1;
      end
      PS_MAJ: begin
        if (c == CH_DOT) ctx_next.parse_state = PS_MIN_FIRST;
        else if (!is_dig) fail = 1'b1;
      end
      PS_MIN_FIRST: begin
        if (is_dig) ctx_next.parse_state = PS_MIN; else fail = 1'b1;
      end
      PS_MIN: begin
        if (c == CH_SPACE) ctx_next.parse_state = PS_DIGITS;
        else if (!is_dig) fail = 1'b1;
      end
      PS_DIGITS: begin
        if (c == CH_SPACE) begin
          // spaces before or between the digits are skipped
        end else if (!is_dig) begin
          fail = 1'b1;
        end else begin
          ctx_next.code_accumulator = acc_wide[CODE_W-1:0];
          ctx_next.digit_count      = cur.digit_count + 2'd1;
          if (ctx_next.digit_count == LAST_DIGIT) begin
            ctx_next.parse_state = PS_AFTER_CODE;
            res.code_valid       = 1'b1;
            res.code_offset      = (at >= OFFSET_BITS'(2)) ? to_field(at - OFFSET_BITS'(2))
                                                           : '0;
          end
        end
      end
      PS_AFTER_CODE: begin
        if (c == CH_SPACE || c == CH_DOT) begin
          ctx_next.parse_state = PS_REASON;
        end else if (c == CH_CR) begin
          ctx_next.parse_state = PS_LINE_LF;
        end else if (c == CH_LF) begin
          ctx_next.parse_state = PS_BODY;
          res.parse_status     = ST_DONE;
          res.head_end_offset  = to_field(at);
        end else begin
          fail = 1'b1;
        end
      end
      PS_REASON: begin
        if (c == CH_CR) begin
          ctx_next.parse_state = PS_LINE_LF;
        end else if (c == CH_LF) begin
          ctx_next.parse_state = PS_BODY;
          res.parse_status     = ST_DONE;
          res.head_end_offset  = to_field(at);
        end
      end
      PS_LINE_LF: begin
        if (c == CH_LF) ctx_next.parse_state = PS_KEY_FIRST; else fail = 1'b1;
      end
      PS_KEY_FIRST, PS_NEXT_LINE: begin
        if (c == CH_CR) begin
          ctx_next.parse_state = PS_END_LF;
        end else begin
          ctx_next.field_start = to_field(at);
          ctx_next.field_count = FIELD_W'(1);
          ctx_next.parse_state = PS_KEY;
        end
      end
      PS_KEY: begin
        if (c == CH_COLON) begin
          res.key_done         = 1'b1;
          res.key_offset       = cur.field_start;
          res.key_length       = cur.field_count;
          ctx_next.parse_state = PS_VAL_FIRST;
        end else if (cur.field_count != COUNT_MAX) begin
          ctx_next.field_count = cur.field_count + FIELD_W'(1);
        end
      end
      PS_VAL_FIRST: begin
        if (c == CH_SPACE) begin
          // leading spaces of a value are skipped
        end else if (c == CH_CR || c == CH_LF) begin
          fail = 1'b1;
        end else begin
          ctx_next.field_start = to_field(at);
          ctx_next.field_count = FIELD_W'(1);
          ctx_next.parse_state = PS_VAL;
        end
      end
      PS_VAL: begin
        if (c == CH_CR) begin
          res.value_done       = 1'b1;
          res.value_offset     = cur.field_start;
          res.value_length     = cur.field_count;
          ctx_next.parse_state = PS_VAL_LF;
        end else if (cur.field_count != COUNT_MAX) begin
          ctx_next.field_count = cur.field_count + FIELD_W'(1);
        end
      end
      PS_VAL_LF: begin
        if (c == CH_LF) ctx_next.parse_state = PS_NEXT_LINE; else fail = 1'b1;
      end
      PS_END_LF: begin
        if (c == CH_LF) begin
          ctx_next.parse_state = PS_BODY;
          res.parse_status     = ST_DONE;
          res.head_end_offset  = (at >= OFFSET_BITS'(1)) ? to_field(at - OFFSET_BITS'(1))
                                                         : '0;
        end else begin
          fail = 1'b1;
        end
      end
      PS_BODY: begin
        res.parse_status = ST_BODY;
      end
      default: begin
        fail = 1'b1;
      end
    endcase

    if (fail) begin
      ctx_next.parse_state = PS_FAIL;
      res                  = '0;
      res.parse_status     = ST_ERR;
    end

    // code is reported on every byte, errors included
    res.status_code = ctx_next.code_accumulator;

    if (cur.byte_offset != '1) ctx_next.byte_offset = cur.byte_offset + OFFSET_BITS'(1);
  end

endmodule

// File: hw/rtl/hrhp_checker.sv
// ============================================================================
// hrhp_checker - port-level checks of the head parser
// Watches the result channel of the top level; bound in below.
// ============================================================================
module hrhp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [hrhp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input logic [hrhp_pkg::OUT_TUSER_W-1:0]    m_tuser
);
  import hrhp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // at most one delimiter strobe per byte
  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tuser[4:2]))
    else $error("more than one strobe on one byte");

  // third digit only ever reported while the head is still open
  a_code_more: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_MORE)
    else $error("code strobe with wrong status");

  // error bytes carry no strobes and no offsets
  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == ST_ERR |-> m_tuser[4:2] == 3'b000 && m_tdata[111:10] == '0)
    else $error("error result not cleared");

  // head end offset only on completion
  a_hend_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != ST_DONE |-> m_tdata[105:90] == '0)
    else $error("head end offset outside completion");

endmodule

bind http_response_head_parser_core hrhp_checker u_hrhp_checker (.*);

// File: tb/hrhp_head_checker.sv
// ============================================================================
// hrhp_head_checker - result checker for the HTTP response head parser
// Watches both stream channels, predicts one result per accepted byte and
// compares each result transfer field by field with the oldest prediction.
// ============================================================================
module hrhp_head_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [hrhp_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [hrhp_pkg::IN_TUSER_W-1:0]  s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [hrhp_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic [hrhp_pkg::OUT_TUSER_W-1:0] m_tuser,
  output int                               fail_count,
  output int                               pending
);
  import hrhp_pkg::*;

  // parser state as predicted
  parse_state_t           phase;
  logic [OFFSET_BITS-1:0] cursor;
  logic [CODE_W-1:0]      code_acc;
  logic [1:0]             digits_seen;
  logic [FIELD_W-1:0]     fld_start;
  logic [FIELD_W-1:0]     fld_count;

  result_t awaited_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic void restart_parser();
    phase       = PS_START;
    cursor      = '0;
    code_acc    = '0;
    digits_seen = '0;
    fld_start   = '0;
    fld_count   = '0;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic void grow_field();
    if (fld_count != COUNT_MAX) fld_count = fld_count + 1'b1;
  endfunction

  // Advance the parser by one byte and return the result it reports.
  function automatic result_t parse_byte(input logic [7:0] c, input logic restart);
    result_t                r;
    logic [OFFSET_BITS-1:0] at;
    logic                   bad;
    int                     acc;
    r   = '0;
    bad = 1'b0;
    if (restart) restart_parser();
    at = cursor;
    case (phase)
      PS_START:     if (c == CH_H) phase = PS_H; else bad = 1'b1;
      PS_H:         if (c == CH_T) phase = PS_HT; else bad = 1'b1;
      PS_HT:        if (c == CH_T) phase = PS_HTT; else bad = 1'b1;
      PS_HTT:       if (c == CH_P) phase = PS_HTTP; else bad = 1'b1;
      PS_HTTP:      if (c == CH_SLASH) phase = PS_MAJ_FIRST; else bad = 1'b1;
      PS_MAJ_FIRST: if (c >= CH_1 && c <= CH_9) phase = PS_MAJ; else bad = 1'b1;
      PS_MAJ: begin
        if (c == CH_DOT) phase = PS_MIN_FIRST;
        else if (!is_digit(c)) bad = 1'b1;
      end
      PS_MIN_FIRST: if (is_digit(c)) phase = PS_MIN; else bad = 1'b1;
      PS_MIN: begin
        if (c == CH_SPACE) phase = PS_DIGITS;
        else if (!is_digit(c)) bad = 1'b1;
      end
      PS_DIGITS: begin
        if (c != CH_SPACE) begin
          if (!is_digit(c)) begin
            bad = 1'b1;
          end else begin
            acc         = int'(code_acc) * 10 + int'(c - CH_0);
            code_acc    = acc[CODE_W-1:0];
            digits_seen = digits_seen + 2'd1;
            if (digits_seen == LAST_DIGIT) begin
              phase         = PS_AFTER_CODE;
              r.code_valid  = 1'b1;
              r.code_offset = (at >= OFFSET_BITS'(2)) ? to_field(at - OFFSET_BITS'(2)) : '0;
            end
          end
        end
      end
      PS_AFTER_CODE: begin
        if (c == CH_SPACE || c == CH_DOT) begin
          phase = PS_REASON;
        end else if (c == CH_CR) begin
          phase = PS_LINE_LF;
        end else if (c == CH_LF) begin
          phase             = PS_BODY;
          r.parse_status    = ST_DONE;
          r.head_end_offset = to_field(at);
        end else begin
          bad = 1'b1;
        end
      end
      PS_REASON: begin
        if (c == CH_CR) begin
          phase = PS_LINE_LF;
        end else if (c == CH_LF) begin
          phase             = PS_BODY;
          r.parse_status    = ST_DONE;
          r.head_end_offset = to_field(at);
        end
      end
      PS_LINE_LF: if (c == CH_LF) phase = PS_KEY_FIRST; else bad = 1'b1;
      PS_KEY_FIRST, PS_NEXT_LINE: begin
        if (c == CH_CR) begin
          phase = PS_END_LF;
        end else begin
          fld_start = to_field(at);
          fld_count = FIELD_W'(1);
          phase     = PS_KEY;
        end
      end
      PS_KEY: begin
        if (c == CH_COLON) begin
          r.key_done   = 1'b1;
          r.key_offset = fld_start;
          r.key_length = fld_count;
          phase        = PS_VAL_FIRST;
        end else begin
          grow_field();
        end
      end
      PS_VAL_FIRST: begin
        if (c == CH_CR || c == CH_LF) begin
          bad = 1'b1;
        end else if (c != CH_SPACE) begin
          fld_start = to_field(at);
          fld_count = FIELD_W'(1);
          phase     = PS_VAL;
        end
      end
      PS_VAL: begin
        if (c == CH_CR) begin
          r.value_done   = 1'b1;
          r.value_offset = fld_start;
          r.value_length = fld_count;
          phase          = PS_VAL_LF;
        end else begin
          grow_field();
        end
      end
      PS_VAL_LF: if (c == CH_LF) phase = PS_NEXT_LINE; else bad = 1'b1;
      PS_END_LF: begin
        if (c == CH_LF) begin
          phase             = PS_BODY;
          r.parse_status    = ST_DONE;
          r.head_end_offset = (at >= OFFSET_BITS'(1)) ? to_field(at - OFFSET_BITS'(1)) : '0;
        end else begin
          bad = 1'b1;
        end
      end
      PS_BODY: r.parse_status = ST_BODY;
      default: bad = 1'b1;
    endcase
    if (bad) begin
      phase          = PS_FAIL;
      r              = '0;
      r.parse_status = ST_ERR;
    end
    r.status_code = code_acc;
    if (cursor != '1) cursor = cursor + 1'b1;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      restart_parser();
      awaited_results.delete();
    end else begin
      // result side first: a byte accepted now cannot have its result yet
      if (m_tvalid && m_tready) begin
        got.parse_status    = parse_status_t'(m_tuser[1:0]);
        got.code_valid      = m_tuser[2];
        got.key_done        = m_tuser[3];
        got.value_done      = m_tuser[4];
        got.status_code     = m_tdata[9:0];
        got.code_offset     = m_tdata[25:10];
        got.key_offset      = m_tdata[41:26];
        got.key_length      = m_tdata[57:42];
        got.value_offset    = m_tdata[73:58];
        got.value_length    = m_tdata[89:74];
        got.head_end_offset = m_tdata[105:90];
        if (awaited_results.size() == 0) begin
          $error("result transfer with no byte outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("parse_status", 32'(want.parse_status), 32'(got.parse_status));
          check_field("code_valid", 32'(want.code_valid), 32'(got.code_valid));
          check_field("status_code", 32'(want.status_code), 32'(got.status_code));
          check_field("code_offset", 32'(want.code_offset), 32'(got.code_offset));
          check_field("key_done", 32'(want.key_done), 32'(got.key_done));
          check_field("key_offset", 32'(want.key_offset), 32'(got.key_offset));
          check_field("key_length", 32'(want.key_length), 32'(got.key_length));
          check_field("value_done", 32'(want.value_done), 32'(got.value_done));
          check_field("value_offset", 32'(want.value_offset), 32'(got.value_offset));
          check_field("value_length", 32'(want.value_length), 32'(got.value_length));
          check_field("head_end_offset", 32'(want.head_end_offset),
                      32'(got.head_end_offset));
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(parse_byte(s_tdata, s_tuser[0]));
    end
    pending = awaited_results.size();
  end

endmodule

// File: tb/tb.sv
// ============================================================================
// tb - testbench of the HTTP response head parser
// Feeds short directed byte runs, then random responses (mostly well formed,
// some corrupted or truncated, some plain noise). The checker beside the
// block predicts and compares every result transfer.
// ============================================================================
module tb;
  import hrhp_pkg::*;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] data_byte
  logic [IN_TUSER_W-1:0]  s_tuser  = '0;   // [0] new_response
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // code, offsets, lengths (see dut)
  logic [OUT_TUSER_W-1:0] m_tuser;         // [1:0] status, [2] code, [3] key, [4] value
  int                     fail_count;
  int                     pending;

  // sender burst bookkeeping
  int   burst_left = 0;

  // receiver stall pattern: a new mode each time the 8-bit stall_tick wraps
  logic [7:0] stall_tick = '0;
  logic [1:0] stall_mode = '0;

  in_item_t msg_bytes[$];

  always #5 clk = ~clk;

  http_response_head_parser_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  hrhp_head_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Mode 0 never stalls, so long stall-free stretches occur naturally.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_tick <= '0;
      stall_mode <= '0;
    end else begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick == '0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= (stall_tick[1:0] != 2'd0);
        2'd2:    m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= (stall_tick % 3 == 0);
      endcase
    end
  end

  // One byte transfer. Entered and left at a rising edge; s_tready is looked
  // at on the falling edge, where nothing is in flux.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 40);
      else gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid   <= 1'b1;
    s_tdata    <= b;
    s_tuser[0] <= restart;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // Hold off the sender until every predicted result has been seen.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    burst_left = 0;
  endtask

  task automatic send_msg();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i].data_byte, msg_bytes[i].new_response);
  endtask

  // first byte of a message always opens a new response
  function automatic void put(input logic [7:0] b);
    in_item_t it;
    it.data_byte    = b;
    it.new_response = (msg_bytes.size() == 0);
    msg_bytes.push_back(it);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic logic [7:0] rand_byte_but(input logic [7:0] a, b, c);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == a || v == b || v == c);
    return v;
  endfunction

  function automatic logic [7:0] rand_digit(input int lo);
    return 8'(int'(CH_0) + $urandom_range(lo, 9));
  endfunction

  // A well-formed response with random content, sometimes damaged.
  function automatic void build_response();
    int       n;
    int       cut;
    logic     headers;
    msg_bytes.delete();
    put(CH_H); put(CH_T); put(CH_T); put(CH_P); put(CH_SLASH);
    put(rand_digit(1));
    repeat ($urandom_range(0, 1)) put(rand_digit(0));
    put(CH_DOT);
    repeat ($urandom_range(1, 2)) put(rand_digit(0));
    put(CH_SPACE);
    // status digits, spaces now and then before or between them
    repeat (3) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put(CH_SPACE);
      put(rand_digit(0));
    end
    // end of status line: bare LF, CR LF, or reason text
    headers = 1'b1;
    case ($urandom_range(0, 5))
      0: begin
        put(CH_LF);
        headers = 1'b0;
      end
      1: begin
        put(CH_CR); put(CH_LF);
      end
      default: begin
        put($urandom_range(0, 3) == 0 ? CH_DOT : CH_SPACE);
        repeat ($urandom_range(0, 8)) put(rand_byte_but(CH_CR, CH_LF, CH_LF));
        if ($urandom_range(0, 3) == 0) begin
          put(CH_LF);
          headers = 1'b0;
        end else begin
          put(CH_CR); put(CH_LF);
        end
      end
    endcase
    if (headers) begin
      repeat ($urandom_range(0, 4)) begin
        // key: a colon is only part of the key as its first byte
        if ($urandom_range(0, 7) == 0) put(CH_COLON);
        else put(rand_byte_but(CH_CR, CH_COLON, CH_COLON));
        repeat ($urandom_range(0, 7)) put(rand_byte_but(CH_COLON, CH_COLON, CH_COLON));
        put(CH_COLON);
        repeat ($urandom_range(0, 2)) put(CH_SPACE);
        put(rand_byte_but(CH_SPACE, CH_CR, CH_LF));
        repeat ($urandom_range(0, 10)) put(rand_byte_but(CH_CR, CH_CR, CH_CR));
        put(CH_CR); put(CH_LF);
      end
      put(CH_CR); put(CH_LF);
    end
    repeat ($urandom_range(0, 4)) put(8'($urandom_range(0, 255)));
    // damage: one byte replaced, or the response cut short
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, msg_bytes.size() - 1);
      if ($urandom_range(0, 1) == 0) begin
        msg_bytes[n].data_byte = 8'($urandom_range(0, 255));
      end else begin
        cut = msg_bytes.size() - n;
        repeat (cut) void'(msg_bytes.pop_back());
      end
    end
  endfunction

  // Raw noise, new_response set at random.
  function automatic void build_noise();
    in_item_t it;
    msg_bytes.delete();
    repeat ($urandom_range(1, 10)) begin
      it.data_byte    = 8'($urandom_range(0, 255));
      it.new_response = 1'($urandom_range(0, 1));
      msg_bytes.push_back(it);
    end
  endfunction

  initial begin
    int sent;
    int mid_pause_done;
    sent           = 0;
    mid_pause_done = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Power-up without new_response: bad first byte, then the error sticks.
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    // Spaces around the digits, LF straight after the code, one body byte.
    msg_bytes.delete();
    put_text("HTTP/9.10 2 0 4\n");
    put(8'hff);
    send_msg();
    // Restart mid-stream and fail inside the prefix.
    msg_bytes.delete();
    put(CH_H);
    put(8'h00);
    send_msg();
    wait_drained();

    // Random responses, with one pause for the pipeline to empty midway.
    while (sent < 1200) begin
      if ($urandom_range(0, 15) == 0) build_noise();
      else build_response();
      send_msg();
      sent += msg_bytes.size();
      if (sent >= 600 && mid_pause_done == 0) begin
        wait_drained();
        mid_pause_done = 1;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
